// ===== rtl/core/olf_pkg.sv =====
package olf_pkg;

  localparam int MAX_POINTS_DEF  = 65536;
  localparam int COORD_BITS_DEF  = 16;
  localparam int COORD_W         = 16;
  localparam int SUM_W           = 33;
  localparam int SQ_W            = 48;
  localparam int WIDE_W          = 64;
  localparam int DBL_W           = 128;
  localparam int SLOPE_W         = 32;
  localparam int ICPT_W          = 48;
  localparam int STAT_W          = 2;
  localparam int FRAC_BITS       = 16;
  localparam int ITER_CNT_W      = 7;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_VERT = 2'd2,
    ST_SAT  = 2'd3
  } fit_status_t;

  typedef enum logic [1:0] {
    IT_MUL,
    IT_DIV,
    IT_SQRT
  } iter_op_t;

  typedef enum logic [3:0] {
    CS_ACC,
    CS_CNT,
    CS_MXX,
    CS_MX2,
    CS_MYY,
    CS_MY2,
    CS_MXY,
    CS_MXY2,
    CS_QA,
    CS_QB,
    CS_SQ,
    CS_CHK,
    CS_DV1,
    CS_MT,
    CS_DV2,
    CS_FIN
  } olf_state_t;

  typedef struct packed {
    olf_state_t step;
    logic       take;
    logic       start;
    logic       fin;
  } olf_cmd_t;

  typedef struct packed {
    logic last_taken;
    logic few;
    logic den_zero;
    logic iter_done;
    logic out_free;
  } olf_stat_t;

endpackage

// ===== rtl/core/olf_iter.sv =====
module olf_iter
  import olf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  iter_op_t             op,
  input  logic [DBL_W-1:0]     opa,
  input  logic [WIDE_W-1:0]    opb,
  output logic                 done,
  output logic [DBL_W-1:0]     res
);

  localparam int REM_W = WIDE_W + 4;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  iter_op_t              op_r, op_nxt;
  logic [ITER_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DBL_W-1:0]      a_r, a_nxt;
  logic [WIDE_W-1:0]     b_r, b_nxt;
  logic [DBL_W-1:0]      acc_r, acc_nxt;
  logic [WIDE_W-1:0]     root_r, root_nxt;
  logic [WIDE_W:0]       drem_s;
  logic [REM_W-1:0]      srem_s, strial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r   <= op_nxt;
    cnt_r  <= cnt_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    root_r <= root_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    root_nxt = root_r;
    drem_s   = {acc_r[WIDE_W-1:0], a_r[DBL_W-1]};
    srem_s   = {acc_r[REM_W-3:0], a_r[DBL_W-1 -: 2]};
    strial   = {2'b00, root_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      op_nxt   = op;
      cnt_nxt  = (op == IT_DIV) ? ITER_CNT_W'(DBL_W - 1) : ITER_CNT_W'(WIDE_W - 1);
      a_nxt    = opa;
      b_nxt    = opb;
      acc_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      case (op_r)
        IT_MUL: begin
          if (b_r[0]) acc_nxt = acc_r + a_r;
          a_nxt = a_r << 1;
          b_nxt = b_r >> 1;
        end
        IT_DIV: begin
          if (drem_s >= {1'b0, b_r}) begin
            acc_nxt = DBL_W'(drem_s - {1'b0, b_r});
            a_nxt   = {a_r[DBL_W-2:0], 1'b1};
          end else begin
            acc_nxt = DBL_W'(drem_s);
            a_nxt   = {a_r[DBL_W-2:0], 1'b0};
          end
        end
        IT_SQRT: begin
          if (srem_s >= strial) begin
            acc_nxt  = DBL_W'(srem_s - strial);
            root_nxt = {root_r[WIDE_W-2:0], 1'b1};
          end else begin
            acc_nxt  = DBL_W'(srem_s);
            root_nxt = {root_r[WIDE_W-2:0], 1'b0};
          end
          a_nxt = a_r << 2;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    case (op_r)
      IT_MUL:  res = acc_r;
      IT_DIV:  res = a_r;
      IT_SQRT: res = {{(DBL_W-WIDE_W){1'b0}}, root_r};
      default: res = '0;
    endcase
  end

  assign done = done_r;

endmodule

// ===== rtl/core/olf_dp.sv =====
module olf_dp
  import olf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  olf_cmd_t             cmd,
  output olf_stat_t            stat,
  input  logic                 in_tvalid,
  input  logic [31:0]          in_tdata,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [79:0]          out_tdata,
  output logic [1:0]           out_tuser
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [SQ_W-1:0]  sxx_r, sxx_nxt, sxy_r, sxy_nxt, syy_r, syy_nxt;
  logic [WIDE_W-1:0]       cxx_r, cxx_nxt, cyy_r, cyy_nxt, cxy_r, cxy_nxt;
  logic [DBL_W-1:0]        q_r, q_nxt;
  logic [WIDE_W-1:0]       rt_r, rt_nxt, num_r, num_nxt, den_r, den_nxt;
  logic [SLOPE_W-1:0]      slope_r, slope_nxt;
  logic [WIDE_W-1:0]       mag_r, mag_nxt;
  logic                    tneg_r, tneg_nxt;
  logic [ICPT_W-1:0]       icpt_r, icpt_nxt;
  fit_status_t             st_r, st_nxt;
  logic                    sat_r, sat_nxt;
  logic                    ov_r, ov_nxt;
  logic [SLOPE_W-1:0]      os_r, os_nxt;
  logic [ICPT_W-1:0]       oi_r, oi_nxt;
  fit_status_t             ost_r, ost_nxt;

  logic signed [COORD_W-1:0]   x_s, y_s;
  logic signed [2*COORD_W-1:0] pxx, pxy, pyy;
  logic                        accept;
  logic [WIDE_W-1:0]           d_s, ad_s, axy_s, two_s, den_s, num_s;
  logic [WIDE_W-1:0]           sx64, sy64, t_s, slope64;
  logic                        dneg_s;
  iter_op_t                    it_op;
  logic [DBL_W-1:0]            it_a, it_res;
  logic [WIDE_W-1:0]           it_b;
  logic                        it_done;
  logic [SLOPE_W-1:0]          slim, smag;
  logic                        ssat;
  logic [ICPT_W-1:0]           ilim, imag;
  logic                        isat;

  olf_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .op    (it_op),
    .opa   (it_a),
    .opb   (it_b),
    .done  (it_done),
    .res   (it_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sx_r   <= '0;
      sy_r   <= '0;
      sxx_r  <= '0;
      sxy_r  <= '0;
      syy_r  <= '0;
      ov_r   <= 1'b0;
      st_r   <= ST_OK;
      sat_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      sxx_r  <= sxx_nxt;
      sxy_r  <= sxy_nxt;
      syy_r  <= syy_nxt;
      ov_r   <= ov_nxt;
      st_r   <= st_nxt;
      sat_r  <= sat_nxt;
    end
    cxx_r   <= cxx_nxt;
    cyy_r   <= cyy_nxt;
    cxy_r   <= cxy_nxt;
    q_r     <= q_nxt;
    rt_r    <= rt_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    slope_r <= slope_nxt;
    mag_r   <= mag_nxt;
    tneg_r  <= tneg_nxt;
    icpt_r  <= icpt_nxt;
    os_r    <= os_nxt;
    oi_r    <= oi_nxt;
    ost_r   <= ost_nxt;
  end

  assign x_s    = COORD_W'($signed(in_tdata[COORD_BITS-1:0]));
  assign y_s    = COORD_W'($signed(in_tdata[COORD_W + COORD_BITS - 1:COORD_W]));
  assign pxx    = x_s * x_s;
  assign pxy    = x_s * y_s;
  assign pyy    = y_s * y_s;
  assign accept = in_tvalid && cmd.take;

  assign sx64    = WIDE_W'(sx_r);
  assign sy64    = WIDE_W'(sy_r);
  assign slope64 = WIDE_W'($signed(slope_r));
  assign d_s     = cxx_r - cyy_r;
  assign dneg_s  = d_s[WIDE_W-1];
  assign ad_s    = dneg_s ? -d_s : d_s;
  assign axy_s   = cxy_r[WIDE_W-1] ? -cxy_r : cxy_r;
  assign two_s   = axy_s << 1;
  assign den_s   = dneg_s ? two_s : ad_s + rt_r;
  assign num_s   = dneg_s ? rt_r + ad_s : two_s;
  assign t_s     = (sy64 << FRAC_BITS) - it_res[WIDE_W-1:0];

  always_comb begin
    it_op = IT_MUL;
    it_a  = '0;
    it_b  = '0;
    case (cmd.step)
      CS_MXX: begin
        it_a = DBL_W'(cnt_r);
        it_b = WIDE_W'(sxx_r);
      end
      CS_MX2: begin
        it_a = DBL_W'(sx64);
        it_b = sx64;
      end
      CS_MYY: begin
        it_a = DBL_W'(cnt_r);
        it_b = WIDE_W'(syy_r);
      end
      CS_MY2: begin
        it_a = DBL_W'(sy64);
        it_b = sy64;
      end
      CS_MXY: begin
        it_a = DBL_W'(cnt_r);
        it_b = WIDE_W'(sxy_r);
      end
      CS_MXY2: begin
        it_a = DBL_W'(sx64);
        it_b = sy64;
      end
      CS_QA: begin
        it_a = DBL_W'(ad_s);
        it_b = ad_s;
      end
      CS_QB: begin
        it_a = DBL_W'(two_s);
        it_b = two_s;
      end
      CS_SQ: begin
        it_op = IT_SQRT;
        it_a  = q_r;
      end
      CS_DV1: begin
        it_op = IT_DIV;
        it_a  = (DBL_W'(num_r) << FRAC_BITS) + DBL_W'(den_r >> 1);
        it_b  = den_r;
      end
      CS_MT: begin
        it_a = DBL_W'(slope64);
        it_b = sx64;
      end
      CS_DV2: begin
        it_op = IT_DIV;
        it_a  = DBL_W'(mag_r + WIDE_W'(cnt_r >> 1));
        it_b  = WIDE_W'(cnt_r);
      end
      default: begin
        it_op = IT_MUL;
      end
    endcase
  end

  always_comb begin
    slim = cxy_r[WIDE_W-1] ? SLOPE_W'(33'h1_0000_0000 >> 1) : {1'b0, {(SLOPE_W-1){1'b1}}};
    ssat = (|it_res[DBL_W-1:SLOPE_W]) || (it_res[SLOPE_W-1:0] > slim);
    smag = ssat ? slim : it_res[SLOPE_W-1:0];
    ilim = tneg_r ? {1'b1, {(ICPT_W-1){1'b0}}} : {1'b0, {(ICPT_W-1){1'b1}}};
    isat = (|it_res[WIDE_W-1:ICPT_W]) || (it_res[ICPT_W-1:0] > ilim);
    imag = isat ? ilim : it_res[ICPT_W-1:0];
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    sxx_nxt   = sxx_r;
    sxy_nxt   = sxy_r;
    syy_nxt   = syy_r;
    cxx_nxt   = cxx_r;
    cyy_nxt   = cyy_r;
    cxy_nxt   = cxy_r;
    q_nxt     = q_r;
    rt_nxt    = rt_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    slope_nxt = slope_r;
    mag_nxt   = mag_r;
    tneg_nxt  = tneg_r;
    icpt_nxt  = icpt_r;
    st_nxt    = st_r;
    sat_nxt   = sat_r;
    ov_nxt    = ov_r;
    os_nxt    = os_r;
    oi_nxt    = oi_r;
    ost_nxt   = ost_r;

    if (accept && (cnt_r < CNT_W'(MAX_POINTS))) begin
      cnt_nxt = cnt_r + 1'b1;
      sx_nxt  = sx_r + SUM_W'(x_s);
      sy_nxt  = sy_r + SUM_W'(y_s);
      sxx_nxt = sxx_r + SQ_W'(pxx);
      sxy_nxt = sxy_r + SQ_W'(pxy);
      syy_nxt = syy_r + SQ_W'(pyy);
    end

    case (cmd.step)
      CS_CNT: begin
        st_nxt  = (cnt_r < CNT_W'(2)) ? ST_FEW : ST_OK;
        sat_nxt = 1'b0;
      end
      CS_CHK: begin
        num_nxt = num_s;
        den_nxt = den_s;
        if (den_s == '0) st_nxt = ST_VERT;
      end
      default: begin
        st_nxt = st_r;
      end
    endcase

    if (it_done) begin
      case (cmd.step)
        CS_MXX:  cxx_nxt = it_res[WIDE_W-1:0];
        CS_MX2:  cxx_nxt = cxx_r - it_res[WIDE_W-1:0];
        CS_MYY:  cyy_nxt = it_res[WIDE_W-1:0];
        CS_MY2:  cyy_nxt = cyy_r - it_res[WIDE_W-1:0];
        CS_MXY:  cxy_nxt = it_res[WIDE_W-1:0];
        CS_MXY2: cxy_nxt = cxy_r - it_res[WIDE_W-1:0];
        CS_QA:   q_nxt   = it_res;
        CS_QB:   q_nxt   = q_r + it_res;
        CS_SQ:   rt_nxt  = it_res[WIDE_W-1:0];
        CS_DV1: begin
          slope_nxt = cxy_r[WIDE_W-1] ? -smag : smag;
          if (ssat) sat_nxt = 1'b1;
        end
        CS_MT: begin
          tneg_nxt = t_s[WIDE_W-1];
          mag_nxt  = t_s[WIDE_W-1] ? -t_s : t_s;
        end
        CS_DV2: begin
          icpt_nxt = tneg_r ? -imag : imag;
          if (isat) sat_nxt = 1'b1;
        end
        default: begin
          q_nxt = q_r;
        end
      endcase
    end

    if (cmd.fin) begin
      ov_nxt = 1'b1;
      if (st_r == ST_OK) begin
        os_nxt  = slope_r;
        oi_nxt  = icpt_r;
        ost_nxt = sat_r ? ST_SAT : ST_OK;
      end else begin
        os_nxt  = '0;
        oi_nxt  = '0;
        ost_nxt = st_r;
      end
      cnt_nxt = '0;
      sx_nxt  = '0;
      sy_nxt  = '0;
      sxx_nxt = '0;
      sxy_nxt = '0;
      syy_nxt = '0;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  assign stat.last_taken = accept && in_tlast;
  assign stat.few        = cnt_r < CNT_W'(2);
  assign stat.den_zero   = den_s == '0;
  assign stat.iter_done  = it_done;
  assign stat.out_free   = !ov_r || out_tready;

  assign out_tvalid = ov_r;
  assign out_tdata  = {oi_r, os_r};
  assign out_tuser  = ost_r;

endmodule

// ===== rtl/core/olf_ctrl.sv =====
module olf_ctrl
  import olf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  olf_stat_t stat,
  output olf_cmd_t  cmd
);

  olf_state_t state_r, state_nxt;
  logic       go_r, go_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_ACC;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    go_nxt    = go_r;
    cmd.step  = state_r;
    cmd.take  = 1'b0;
    cmd.start = 1'b0;
    cmd.fin   = 1'b0;
    case (state_r)
      CS_ACC: begin
        cmd.take = 1'b1;
        if (stat.last_taken) state_nxt = CS_CNT;
      end
      CS_CNT: begin
        state_nxt = stat.few ? CS_FIN : CS_MXX;
      end
      CS_CHK: begin
        state_nxt = stat.den_zero ? CS_FIN : CS_DV1;
      end
      CS_FIN: begin
        cmd.fin = stat.out_free;
        if (stat.out_free) state_nxt = CS_ACC;
      end
      default: begin
        if (!go_r) begin
          cmd.start = 1'b1;
          go_nxt    = 1'b1;
        end else if (stat.iter_done) begin
          go_nxt = 1'b0;
          case (state_r)
            CS_MXX:  state_nxt = CS_MX2;
            CS_MX2:  state_nxt = CS_MYY;
            CS_MYY:  state_nxt = CS_MY2;
            CS_MY2:  state_nxt = CS_MXY;
            CS_MXY:  state_nxt = CS_MXY2;
            CS_MXY2: state_nxt = CS_QA;
            CS_QA:   state_nxt = CS_QB;
            CS_QB:   state_nxt = CS_SQ;
            CS_SQ:   state_nxt = CS_CHK;
            CS_DV1:  state_nxt = CS_MT;
            CS_MT:   state_nxt = CS_DV2;
            CS_DV2:  state_nxt = CS_FIN;
            default: state_nxt = CS_ACC;
          endcase
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/orthogonal_line_fit.sv =====
// After the accepted last point, the fit runs on one shared bit-serial unit: eight
// multiplies and a square root, then a divide, a multiply and a divide. With under two
// points it goes straight to the output; for a vertical line it stops after the square root.
// Throughput: one point per cycle while accumulating; no points are taken during a fit, and
// the fit holds in its last cycle until the output register is free.
// Reset (rst_n low, synchronous) clears all sums, the count and the output valid.
module orthogonal_line_fit
  import olf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x_coord[15:0], y_coord[31:16]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // slope[31:0], intercept[79:32]
  output logic [1:0]  out_tuser   // fit_status[1:0]
);

  olf_cmd_t  cmd;
  olf_stat_t stat;

  olf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  olf_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign in_tready = cmd.take;

endmodule

// ===== rtl/core/olf_chk.sv =====
module olf_chk
  import olf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FEW || out_tuser == ST_VERT) |-> out_tdata == '0)
    else $error("fields not cleared on degenerate fit");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("points taken during fit");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind orthogonal_line_fit olf_chk u_olf_chk (.*);
